// ===== src/banked_memory_mapper_macros.svh =====
// Assertion macros for the banked memory mapper.
// Depends on nothing; included by the top level only.
`ifndef BANKED_MEMORY_MAPPER_MACROS_SVH
`define BANKED_MEMORY_MAPPER_MACROS_SVH
`ifndef SYNTHESIS
`define BMM_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("bmm check");
`define BMM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error("bmm seq");
`else
`define BMM_ASSERT(label, clk, rst_n, prop)
`define BMM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/bmm_pkg.sv =====
// Shared constants and types of the banked memory mapper.
// Depends on nothing.
`timescale 1ns / 1ps
package bmm_pkg;
  localparam int RamBytes  = 8192;
  localparam int SramBytes = 32768;
  localparam int MaxBanks  = 256;

  localparam logic [1:0] SRC_CART = 2'd0;
  localparam logic [1:0] SRC_RAM  = 2'd1;
  localparam logic [1:0] SRC_SRAM = 2'd2;
  localparam logic [1:0] SRC_NONE = 2'd3;

  localparam logic [1:0] MAP_STD = 2'd0;
  localparam logic [1:0] MAP_CM  = 2'd1;
  localparam logic [1:0] MAP_KR  = 2'd2;

  localparam logic CFG_MAPPER = 1'b0;
  localparam logic CFG_BANKS  = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic clr_step;   // write zero at clear address
    logic capture;    // latch transaction
    logic mod_step;   // advance bank remainder by one bit
    logic execute;    // perform access
    logic finish;     // emit result
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic mod_busy;
  } sts_t;
endpackage

// ===== src/bmm_ram.sv =====
// Generic single-port RAM with registered read.
// Depends on nothing.
`timescale 1ns / 1ps
module bmm_ram #(
  parameter int Width = 8,
  parameter int Depth = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ===== src/bmm_ctrl.sv =====
// Controller FSM: clearing pass after reset, then capture, remainder steps,
// execute, finish. Depends on bmm_pkg.
`timescale 1ns / 1ps
module bmm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  bmm_pkg::sts_t sts_i,
  output bmm_pkg::ctl_t ctl_o
);
  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        ctl_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          ctl_o.capture = 1'b1;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts_i.mod_busy) begin
          ctl_o.mod_step = 1'b1;
        end else begin
          ctl_o.execute = 1'b1;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        ctl_o.finish = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

// ===== src/bmm_dp.sv =====
// Datapath: slot map, paging registers, work RAM and SRAM, result register.
// Depends on bmm_pkg and bmm_ram.
`timescale 1ns / 1ps
module bmm_dp #(
  parameter int RamBytes  = bmm_pkg::RamBytes,
  parameter int SramBytes = bmm_pkg::SramBytes,
  parameter int MaxBanks  = bmm_pkg::MaxBanks
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  bmm_pkg::ctl_t ctl_i,
  output bmm_pkg::sts_t sts_o,
  input  logic          cfg_we_i,
  input  logic          cfg_idx_i,
  input  logic [8:0]    cfg_data_i,
  input  logic          command_i,
  input  logic [15:0]   address_i,
  input  logic [7:0]    write_data_i,
  output logic          done_o,
  output logic [7:0]    read_data_o,
  output logic          from_cartridge_o,
  output logic [21:0]   cartridge_address_o,
  output logic          sram_used_o
);
  localparam int RamAw  = $clog2(RamBytes);
  localparam int SramAw = $clog2(SramBytes);

  logic [1:0]  mapper_q;
  logic [8:0]  banks_q;
  logic [7:0]  pb_q [4];
  logic [1:0]  rsrc_q [8];
  logic [8:0]  rblk_q [8];
  logic [1:0]  wsrc_q [8];
  logic [1:0]  wblk_q [8];
  logic        sflag_q;
  logic        cmd_q;
  logic [15:0] addr_q;
  logic [7:0]  data_q;
  logic [SramAw-1:0] clr_q;
  logic [3:0]  mod_cnt_q;
  logic [7:0]  div_q;
  logic [7:0]  rem_q;

  logic [2:0]  slot;
  logic [12:0] off;
  logic [8:0]  nbank;
  logic [7:0]  pval, page;
  logic [7:0]  div_src, rem_src;
  logic [8:0]  rem_try;
  logic        pg_single, pg_std, pg_req;
  logic [RamAw-1:0]  ram_addr;
  logic [SramAw-1:0] sram_addr;
  logic        ram_we, sram_we;
  logic [7:0]  ram_wd, ram_rd, sram_wd, sram_rd;

  assign slot = addr_q[15:13];
  assign off  = addr_q[12:0];
  assign nbank = (banks_q == 9'd0 || banks_q > 9'(MaxBanks)) ? 9'(MaxBanks) : banks_q;

  assign pg_single = cmd_q &&
                     ((mapper_q == bmm_pkg::MAP_CM && addr_q == 16'h8000) ||
                      (mapper_q == bmm_pkg::MAP_KR && addr_q == 16'hA000));
  assign pg_std = cmd_q && mapper_q != bmm_pkg::MAP_CM && mapper_q != bmm_pkg::MAP_KR &&
                  addr_q >= 16'hFFFC;
  assign pg_req = pg_single || pg_std;

  // Serial remainder of the page byte by the bank count, one bit per step
  assign pval    = (pg_std && addr_q[1:0] == 2'd0) ? pb_q[3] : data_q;
  assign div_src = (mod_cnt_q == 4'd0) ? pval : div_q;
  assign rem_src = (mod_cnt_q == 4'd0) ? 8'd0 : rem_q;
  assign rem_try = {rem_src, div_src[7]};
  assign page    = rem_q;

  always_comb begin
    ram_addr  = off[RamAw-1:0];
    sram_addr = SramAw'({wblk_q[slot], off});
    ram_we  = 1'b0;
    sram_we = 1'b0;
    ram_wd  = data_q;
    sram_wd = data_q;
    if (ctl_i.clr_step) begin
      ram_addr  = clr_q[RamAw-1:0];
      sram_addr = clr_q;
      ram_we  = 1'b1;
      sram_we = 1'b1;
      ram_wd  = 8'd0;
      sram_wd = 8'd0;
    end else if (!cmd_q) begin
      sram_addr = SramAw'({rblk_q[slot][1:0], off});
    end else if (ctl_i.execute && !pg_single) begin
      ram_we  = (wsrc_q[slot] == bmm_pkg::SRC_RAM);
      sram_we = (wsrc_q[slot] == bmm_pkg::SRC_SRAM);
    end
  end

  bmm_ram #(.Width(8), .Depth(RamBytes)) u_ram (
    .clk_i, .we_i(ram_we), .addr_i(ram_addr), .wdata_i(ram_wd), .rdata_o(ram_rd)
  );
  bmm_ram #(.Width(8), .Depth(SramBytes)) u_sram (
    .clk_i, .we_i(sram_we), .addr_i(sram_addr), .wdata_i(sram_wd), .rdata_o(sram_rd)
  );

  always_comb begin
    sts_o = '0;
    sts_o.clr_last = (clr_q == '1);
    sts_o.mod_busy = pg_req && (mod_cnt_q != 4'd8);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mapper_q <= bmm_pkg::MAP_STD;
      banks_q  <= 9'd4;
      pb_q[0] <= 8'd0; pb_q[1] <= 8'd0; pb_q[2] <= 8'd1; pb_q[3] <= 8'd2;
      for (int i = 0; i < 8; i++) begin
        rsrc_q[i] <= (i >= 6) ? bmm_pkg::SRC_RAM : bmm_pkg::SRC_CART;
        rblk_q[i] <= (i >= 6) ? 9'd0 : 9'(i);
        wsrc_q[i] <= (i >= 6) ? bmm_pkg::SRC_RAM : bmm_pkg::SRC_NONE;
        wblk_q[i] <= 2'd0;
      end
      sflag_q   <= 1'b0;
      clr_q     <= '0;
      done_o    <= 1'b0;
      mod_cnt_q <= 4'd0;
      div_q     <= 8'd0;
      rem_q     <= 8'd0;
    end else begin
      done_o <= ctl_i.finish;
      if (ctl_i.clr_step) begin
        clr_q <= clr_q + 1'b1;
      end
      if (ctl_i.capture) begin
        mod_cnt_q <= 4'd0;
      end else if (ctl_i.mod_step) begin
        mod_cnt_q <= mod_cnt_q + 4'd1;
        div_q     <= {div_src[6:0], 1'b0};
        rem_q     <= (rem_try >= nbank) ? 8'(rem_try - nbank) : rem_try[7:0];
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == bmm_pkg::CFG_MAPPER) begin
          mapper_q <= cfg_data_i[1:0];
        end else begin
          banks_q <= cfg_data_i;
        end
      end
      if (ctl_i.execute && pg_single) begin
        pb_q[0] <= data_q;
        rsrc_q[4] <= bmm_pkg::SRC_CART; rblk_q[4] <= {page, 1'b0};
        rsrc_q[5] <= bmm_pkg::SRC_CART; rblk_q[5] <= {page, 1'b1};
        wsrc_q[4] <= bmm_pkg::SRC_NONE; wblk_q[4] <= 2'd0;
        wsrc_q[5] <= bmm_pkg::SRC_NONE; wblk_q[5] <= 2'd0;
      end
      if (ctl_i.execute && pg_std) begin
        pb_q[addr_q[1:0]] <= data_q;
        case (addr_q[1:0])
          2'd0: begin
            if (data_q[3]) begin
              sflag_q <= 1'b1;
              rsrc_q[4] <= bmm_pkg::SRC_SRAM; rblk_q[4] <= {7'd0, data_q[2], 1'b0};
              rsrc_q[5] <= bmm_pkg::SRC_SRAM; rblk_q[5] <= {7'd0, data_q[2], 1'b1};
              wsrc_q[4] <= bmm_pkg::SRC_SRAM; wblk_q[4] <= {data_q[2], 1'b0};
              wsrc_q[5] <= bmm_pkg::SRC_SRAM; wblk_q[5] <= {data_q[2], 1'b1};
            end else begin
              rsrc_q[4] <= bmm_pkg::SRC_CART; rblk_q[4] <= {page, 1'b0};
              rsrc_q[5] <= bmm_pkg::SRC_CART; rblk_q[5] <= {page, 1'b1};
              wsrc_q[4] <= bmm_pkg::SRC_NONE; wblk_q[4] <= 2'd0;
              wsrc_q[5] <= bmm_pkg::SRC_NONE; wblk_q[5] <= 2'd0;
            end
          end
          2'd1: begin
            rsrc_q[0] <= bmm_pkg::SRC_CART; rblk_q[0] <= {page, 1'b0};
            rsrc_q[1] <= bmm_pkg::SRC_CART; rblk_q[1] <= {page, 1'b1};
          end
          2'd2: begin
            rsrc_q[2] <= bmm_pkg::SRC_CART; rblk_q[2] <= {page, 1'b0};
            rsrc_q[3] <= bmm_pkg::SRC_CART; rblk_q[3] <= {page, 1'b1};
          end
          default: begin
            if (!pb_q[0][3]) begin
              rsrc_q[4] <= bmm_pkg::SRC_CART; rblk_q[4] <= {page, 1'b0};
              rsrc_q[5] <= bmm_pkg::SRC_CART; rblk_q[5] <= {page, 1'b1};
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      cmd_q  <= command_i;
      addr_q <= address_i;
      data_q <= write_data_i;
    end
  end

  // result; RAM data appears the cycle after execute
  always_ff @(posedge clk_i) begin
    if (ctl_i.execute) begin
      from_cartridge_o    <= 1'b0;
      cartridge_address_o <= '0;
      if (!cmd_q) begin
        if (addr_q < 16'h0400) begin
          from_cartridge_o    <= 1'b1;
          cartridge_address_o <= {9'd0, off};
        end else if (rsrc_q[slot] == bmm_pkg::SRC_CART) begin
          from_cartridge_o    <= 1'b1;
          cartridge_address_o <= {rblk_q[slot], off};
        end
      end
    end
  end

  always_comb begin
    read_data_o = 8'd0;
    if (!cmd_q && !from_cartridge_o) begin
      if (rsrc_q[slot] == bmm_pkg::SRC_RAM) begin
        read_data_o = ram_rd;
      end else if (rsrc_q[slot] == bmm_pkg::SRC_SRAM) begin
        read_data_o = sram_rd;
      end
    end
  end
  assign sram_used_o = sflag_q;
endmodule

// ===== src/banked_memory_mapper.sv =====
// Banked memory mapper: one CPU read or write per transaction, one result
// each, strobed by done_o for a single cycle; the receiver cannot stall.
// A transaction passes through capture, execute with the registered RAM
// read, then the result register; a paging write adds the bit-serial
// remainder by the bank count before execute. busy is low again in the
// done_o cycle, so the next transaction can be accepted at its end. After
// reset a clearing pass zeroes the work RAM and SRAM while busy stays high;
// configuration writes are taken anytime.
// Depends on bmm_pkg, bmm_ctrl, bmm_dp, bmm_ram and the macros header.
`timescale 1ns / 1ps
`include "banked_memory_mapper_macros.svh"
module banked_memory_mapper #(
  parameter int MaxBanks = bmm_pkg::MaxBanks
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [8:0]  cfg_data_i,
  input  logic        command_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  write_data_i,
  output logic        done_o,
  output logic [7:0]  read_data_o,
  output logic        from_cartridge_o,
  output logic [21:0] cartridge_address_o,
  output logic        sram_used_o
);
  bmm_pkg::ctl_t ctl;
  bmm_pkg::sts_t sts;

  bmm_ctrl u_ctrl (.clk_i, .rst_ni, .start, .busy, .sts_i(sts), .ctl_o(ctl));

  bmm_dp #(
    .RamBytes(bmm_pkg::RamBytes), .SramBytes(bmm_pkg::SramBytes), .MaxBanks(MaxBanks)
  ) u_dp (
    .clk_i, .rst_ni, .ctl_i(ctl), .sts_o(sts), .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .command_i, .address_i, .write_data_i, .done_o, .read_data_o, .from_cartridge_o,
    .cartridge_address_o, .sram_used_o
  );

  `BMM_ASSERT_NEXT(a_busy_after_cap, clk_i, rst_ni, ctl.capture, busy)
  `BMM_ASSERT_NEXT(a_done_two_after, clk_i, rst_ni, ctl.execute, ##1 done_o)
  `BMM_ASSERT(a_done_busy_free, clk_i, rst_ni, !(done_o && ctl.clr_step))
  `BMM_ASSERT_NEXT(a_sram_sticky, clk_i, rst_ni, sram_used_o, sram_used_o)
endmodule
